/* hdl/bps_pkg.sv */
// Shared types and constants for the block byte pattern search.
// Used by the cells, the output buffer and the top level; depends on nothing.
`default_nettype none

package bps_pkg;

	localparam int PATTERN_SLOTS = 16;  // bytes held by the two pattern registers
	localparam int SEL_W         = 4;   // index into the pattern bytes
	localparam int LEN_W         = 5;   // pattern_length register width
	localparam int OFFSET_W      = 12;  // match_offset width
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;

	typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                valid;
		logic [OFFSET_W-1:0] offset;
	} result_t;

endpackage

`default_nettype wire

/* hdl/block_byte_pattern_search.sv */
// Top level of the block byte pattern search: configuration registers, block
// position counter, the chain of compare cells and the output buffer.
// Depends on bps_pkg, bps_cell and bps_out_buf.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  data_byte, last_in_block
//   out       source     out_valid/out_stall  match_offset
//   cfg       sink       cfg_write            cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; the whole window compare
// happens in the cycle a byte is taken, and its match is registered in the output
// register, or parked in its skid slot while the output is stalled.
// in_stall rises only when the output register and its skid slot both hold
// results, i.e. after the downstream side has stalled a full result.
// Reset clears the position counter, the buffer and the pattern registers
// (length back to 1); no clearing pass is needed.
`default_nettype none

module block_byte_pattern_search #(
	parameter int MAX_PATTERN = 16,
	parameter int BLOCK_BYTES = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               last_in_block,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [bps_pkg::OFFSET_W-1:0]            match_offset,
	input  wire logic                               cfg_write,
	input  wire logic [bps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int POS_W  = $clog2(BLOCK_BYTES);
	localparam int FILL_W = POS_W + 1;
	localparam int WIDE_W = (FILL_W > bps_pkg::OFFSET_W) ? FILL_W : bps_pkg::OFFSET_W;

	bps_pkg::pattern_t             pattern_q;
	logic [bps_pkg::LEN_W-1:0]     length_q;
	logic [bps_pkg::LEN_W-1:0]     len_eff;
	logic [POS_W-1:0]              pos_q;
	logic [FILL_W-1:0]             filled;
	logic [WIDE_W-1:0]             filled_w;
	logic [WIDE_W-1:0]             len_w;
	logic [WIDE_W-1:0]             start_w;
	logic                          in_accept;
	logic                          window_hit;
	logic                          buf_full;
	bps_pkg::result_t              result;

	logic [MAX_PATTERN-1:0][7:0]   chain_in;
	logic [MAX_PATTERN-1:0][7:0]   chain_out;
	logic [MAX_PATTERN-1:0]        cell_ok;

	assign in_stall  = buf_full;
	assign in_accept = in_valid && !buf_full;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= bps_pkg::LEN_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				bps_pkg::REG_PATTERN_LOW:    pattern_q[7:0]  <= cfg_data;
				bps_pkg::REG_PATTERN_HIGH:   pattern_q[15:8] <= cfg_data;
				bps_pkg::REG_PATTERN_LENGTH: length_q <= cfg_data[bps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (length_q > bps_pkg::LEN_W'(MAX_PATTERN))
		? bps_pkg::LEN_W'(MAX_PATTERN) : length_q;

	// cell chain: cell 0 takes the new byte, the rest take their neighbor's
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign chain_in[k] = data_byte;
		end else begin : g_link
			assign chain_in[k] = chain_out[k-1];
		end

		bps_cell #(
			.INDEX(k)
		) u_cell (
			.clk      (clk),
			.shift_en (in_accept),
			.byte_in  (chain_in[k]),
			.pattern  (pattern_q),
			.length   (len_eff),
			.byte_out (chain_out[k]),
			.byte_ok  (cell_ok[k])
		);
	end

	// block position
	assign filled   = FILL_W'(pos_q) + FILL_W'(1);
	assign filled_w = WIDE_W'(filled);
	assign len_w    = WIDE_W'(len_eff);
	assign start_w  = filled_w - len_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_accept) begin
			if (last_in_block || filled_w >= WIDE_W'(BLOCK_BYTES)) begin
				pos_q <= '0;
			end else begin
				pos_q <= filled[POS_W-1:0];
			end
		end
	end

	// drop windows that are not yet filled within this block
	assign window_hit = (len_eff != '0) && (filled_w >= len_w) && (&cell_ok);

	assign result.valid  = in_accept && window_hit;
	assign result.offset = start_w[bps_pkg::OFFSET_W-1:0];

	bps_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (result),
		.full         (buf_full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_offset (match_offset)
	);

endmodule

`default_nettype wire

/* hdl/bps_cell.sv */
// One cell of the window: holds one recent byte and compares the byte it
// takes in against the pattern byte aligned to its place. Depends on bps_pkg.
`default_nettype none

module bps_cell #(
	parameter int INDEX = 0
) (
	input  wire logic                       clk,
	input  wire logic                       shift_en,
	input  wire logic [7:0]                 byte_in,
	input  wire bps_pkg::pattern_t          pattern,
	input  wire logic [bps_pkg::LEN_W-1:0]  length,
	output logic [7:0]                      byte_out,
	output logic                            byte_ok
);

	logic [7:0]                  byte_q;
	logic                        active;
	logic [bps_pkg::LEN_W-1:0]   sel_full;
	logic [bps_pkg::SEL_W-1:0]   sel;

	// cell k lines up with pattern byte length-1-k
	assign active   = bps_pkg::LEN_W'(INDEX) < length;
	assign sel_full = length - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(INDEX);
	assign sel      = sel_full[bps_pkg::SEL_W-1:0];
	assign byte_ok  = !active || (byte_in == pattern[sel]);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule

`default_nettype wire

/* hdl/bps_out_buf.sv */
// Output register with a skid slot, so a new result can be parked while the
// downstream side stalls. Depends on bps_pkg.
`default_nettype none

module bps_out_buf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bps_pkg::result_t              push,
	output logic                               full,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bps_pkg::OFFSET_W-1:0]       match_offset
);

	logic                          main_valid_q;
	logic [bps_pkg::OFFSET_W-1:0]  main_q;
	logic                          skid_valid_q;
	logic [bps_pkg::OFFSET_W-1:0]  skid_q;
	logic                          pop;

	assign pop = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push.valid;
				end
			end else if (!main_valid_q) begin
				main_valid_q <= push.valid;
			end else if (push.valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end else if (pop || !main_valid_q) begin
			main_q <= push.offset;
		end
		// park the result while the output register is held
		if (!pop && main_valid_q && push.valid) begin
			skid_q <= push.offset;
		end
	end

	assign full         = skid_valid_q;
	assign out_valid    = main_valid_q;
	assign match_offset = main_q;

endmodule

`default_nettype wire

/* hdl/bps_checker.sv */
// Port-level checks for block_byte_pattern_search, bound to the top level.
// Depends on bps_pkg for port widths.
`default_nettype none

module bps_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_stall,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [bps_pkg::OFFSET_W-1:0]    match_offset
);

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_offset))
		else $error("match_offset changed or dropped while stalled");

	// input back-pressure means a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// back-pressure only follows a stalled result transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("in_stall rose without a stalled output");

	// an empty output leaves the skid slot empty in the next cycle
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !in_stall)
		else $error("in_stall one cycle after an empty output");

endmodule

bind block_byte_pattern_search bps_checker u_bps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.match_offset (match_offset)
);

`default_nettype wire

/* dv/bps_match_checker.sv */
// Scoreboard for the block byte pattern search: tracks register writes and
// accepted bytes, predicts match offsets and compares each output transaction.
// Depends on bps_pkg for widths and register codes.
`default_nettype none

module bps_match_checker #(
	parameter int BLOCK_BYTES = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_in_block,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [bps_pkg::OFFSET_W-1:0]    match_offset,
	input  wire logic                            cfg_write,
	input  wire logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                   mismatches,
	output int                                   pending,
	output int                                   offsets_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0]                            pat_low;
	logic [63:0]                            pat_high;
	logic [bps_pkg::LEN_W-1:0]              pat_len;
	logic [bps_pkg::PATTERN_SLOTS-1:0][7:0] window;  // [0] is the newest byte
	int                                     block_pos;
	logic [bps_pkg::OFFSET_W-1:0]           expected_offsets [$];

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches <= mismatches + 1;
	endtask

	// Shift one byte into the window and compare the pattern against the newest bytes.
	function automatic logic scan_byte(input logic [7:0] b, input logic ends_block,
			output logic [bps_pkg::OFFSET_W-1:0] start);
		int           filled;
		int           n;
		logic         hit;
		logic [127:0] pat;
		window = {window[bps_pkg::PATTERN_SLOTS-2:0], b};
		filled = block_pos + 1;
		n = (pat_len > bps_pkg::PATTERN_SLOTS) ? bps_pkg::PATTERN_SLOTS : int'(pat_len);
		pat = {pat_high, pat_low};
		hit = 1'b0;
		start = '0;
		// leftover bytes from the previous block never count
		if (n >= 1 && filled >= n) begin
			hit = 1'b1;
			for (int j = 0; j < n; j++) begin
				if (window[n-1-j] != pat[8*j +: 8])
					hit = 1'b0;
			end
		end
		if (hit)
			start = bps_pkg::OFFSET_W'(filled - n);
		block_pos = (ends_block || filled >= BLOCK_BYTES) ? 0 : filled;
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [bps_pkg::OFFSET_W-1:0] want;
		logic [bps_pkg::OFFSET_W-1:0] found;
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			pat_len = bps_pkg::LEN_W'(1);
			window = '0;
			block_pos = 0;
			expected_offsets.delete();
			mismatches <= 0;
			pending <= 0;
			offsets_checked <= 0;
		end else begin
			// retire the output first: it belongs to a byte taken on an earlier edge
			if (out_valid && !out_stall) begin
				if (expected_offsets.size() == 0) begin
					report_mismatch($sformatf("match_offset %0d with no match outstanding",
						match_offset));
				end else begin
					want = expected_offsets.pop_front();
					if (match_offset !== want)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							match_offset, want));
					else
						offsets_checked <= offsets_checked + 1;
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					bps_pkg::REG_PATTERN_LOW: begin
						pat_low = cfg_data;
					end
					bps_pkg::REG_PATTERN_HIGH: begin
						pat_high = cfg_data;
					end
					bps_pkg::REG_PATTERN_LENGTH: begin
						pat_len = cfg_data[bps_pkg::LEN_W-1:0];
					end
					default: begin
						// unknown index: drop the write
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				if (scan_byte(data_byte, last_in_block, found))
					expected_offsets.insert(expected_offsets.size(), found);
			end
			pending <= expected_offsets.size();
		end
	end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Top of the block byte pattern search testbench: clock, reset, byte stimulus,
// register programming, output stall pattern, watchdog and verdict.
// Depends on bps_pkg, block_byte_pattern_search and bps_match_checker.
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int                              RANDOM_BYTES = 900;
	localparam int                              QUIET_LIMIT  = 2000;
	localparam logic [bps_pkg::CFG_INDEX_W-1:0] REG_UNUSED   = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_RARE,
		STALL_LONG
	} stall_mode_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            in_valid      = 1'b0;
	logic [7:0]                      data_byte     = '0;
	logic                            last_in_block = 1'b0;
	logic                            out_stall     = 1'b0;
	logic                            cfg_write     = 1'b0;
	logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
	wire logic                       in_stall;
	wire logic                       out_valid;
	wire logic [bps_pkg::OFFSET_W-1:0] match_offset;

	int mismatches;
	int pending;
	int offsets_checked;

	int          burst_left    = 0;
	int          bytes_sent    = 0;
	int          random_bytes  = 0;
	int          setting_count = 0;
	int          quiet_cycles  = 0;
	int          cycle_count   = 0;
	int          mode_left     = 0;
	stall_mode_t stall_mode    = STALL_NONE;

	block_byte_pattern_search u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_in_block(last_in_block),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_offset (match_offset),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bps_match_checker u_match_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_in_block  (last_in_block),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.match_offset   (match_offset),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.offsets_checked(offsets_checked)
	);

	always #10 clk = ~clk;

	// Receiver: switch to a randomly chosen stall style whenever the current one runs out.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(40, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
			STALL_RARE: out_stall <= ($urandom_range(0, 7) == 0);
			default:    out_stall <= (cycle_count % 16) < 11;
		endcase
	end

	// Watchdog: end the run if no transaction or register write happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("tb_top failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic ends_block);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_in_block <= ends_block;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Drain all outstanding matches, then program the three registers back to back, and optionally an unused one.
	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [bps_pkg::LEN_W-1:0] len, input bit poke_unused);
		logic [63:0] junk;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		junk = {$urandom, $urandom};
		cfg_write <= 1'b1;
		cfg_index <= bps_pkg::REG_PATTERN_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= bps_pkg::REG_PATTERN_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		// upper bits of the length write are don't-care
		cfg_index <= bps_pkg::REG_PATTERN_LENGTH;
		cfg_data <= {junk[63:bps_pkg::LEN_W], len};
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		setting_count++;
	endtask

	// One setting, then a few blocks built mostly from pattern copies and prefixes.
	task automatic random_phase();
		int                        asize;
		int                        eff;
		int                        blen;
		int                        cut;
		logic [7:0]                alphabet [4];
		logic [7:0]                block_q [$];
		logic [127:0]              packed_pat;
		logic [bps_pkg::LEN_W-1:0] len;
		asize = $urandom_range(1, 4);
		foreach (alphabet[k])
			alphabet[k] = 8'($urandom_range(0, 255));
		for (int j = 0; j < bps_pkg::PATTERN_SLOTS; j++)
			packed_pat[8*j +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
				alphabet[$urandom_range(0, asize - 1)];
		case ($urandom_range(0, 9))
			0:       len = bps_pkg::LEN_W'(0);
			1:       len = bps_pkg::LEN_W'(1);
			2:       len = bps_pkg::LEN_W'(16);
			3:       len = bps_pkg::LEN_W'(31);
			4:       len = bps_pkg::LEN_W'($urandom_range(17, 30));
			default: len = bps_pkg::LEN_W'($urandom_range(2, 15));
		endcase
		eff = (len > bps_pkg::PATTERN_SLOTS) ? bps_pkg::PATTERN_SLOTS : int'(len);
		configure(packed_pat[63:0], packed_pat[127:64], len, $urandom_range(0, 7) == 0);
		repeat ($urandom_range(2, 8)) begin
			block_q.delete();
			blen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
			while (block_q.size() < blen) begin
				case ($urandom_range(0, 5))
					0, 1: begin
						for (int j = 0; j < eff; j++)
							block_q.insert(block_q.size(), packed_pat[8*j +: 8]);
					end
					2: begin
						// broken copy: a prefix only
						if (eff > 1) begin
							cut = $urandom_range(1, eff - 1);
							for (int j = 0; j < cut; j++)
								block_q.insert(block_q.size(), packed_pat[8*j +: 8]);
						end
					end
					3, 4: block_q.insert(block_q.size(), alphabet[$urandom_range(0, asize - 1)]);
					default: block_q.insert(block_q.size(), 8'($urandom_range(0, 255)));
				endcase
			end
			foreach (block_q[i])
				send_byte(block_q[i], i == block_q.size() - 1);
			random_bytes += block_q.size();
		end
	endtask

	// One block that runs past its size limit with no end mark; last slot matches.
	task automatic overrun_block();
		logic [7:0]  target;
		logic [63:0] lo;
		target = 8'($urandom_range(0, 255));
		lo = {$urandom, $urandom};
		lo[7:0] = target;
		configure(lo, {$urandom, $urandom}, bps_pkg::LEN_W'(1), 1'b0);
		repeat (4095)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(target, 1'b0);
		send_byte(target, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: one-byte pattern of zero.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// Overlong length saturates to sixteen; overlapping all-ones matches.
		configure('1, '1, bps_pkg::LEN_W'(20), 1'b0);
		for (int k = 0; k < 17; k++)
			send_byte(8'hFF, k == 16);

		// Zero length finds nothing; unknown register write is ignored.
		configure(64'h0, 64'h0, bps_pkg::LEN_W'(0), 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		// A match may not straddle a block boundary.
		configure(64'h0123_4567_89AB_A55A, 64'hFEDC_BA98_7654_3210, bps_pkg::LEN_W'(2), 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);

		while (random_bytes < RANDOM_BYTES)
			random_phase();
		overrun_block();

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d bytes under %0d register settings, one block overrunning its size;",
			bytes_sent, setting_count);
		$display("compared %0d match offsets, %0d mismatches.", offsets_checked, mismatches);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
